FILE: hdl/bsi_pkg.sv
// Shared types and constants for the bitmap set-bit iterator.
// Used by bsi_scan and bitmap_set_bit_iterator_top; no dependencies.
package bsi_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORD_LOG  = 5;
    localparam int BIT_W     = 12;
    localparam int WIDX_W    = 7;
    localparam int DEF_WORDS = 128;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FWD   = 2'd1;
    localparam logic [1:0] OP_REV   = 2'd2;
    localparam logic [1:0] OP_ADV   = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [WIDX_W-1:0]    word_index;
        logic [WORD_BITS-1:0] word_data;
        logic [BIT_W-1:0]     start_bit;
        logic [BIT_W-1:0]     end_bit;
    } cmd_t;

    typedef struct packed {
        logic [BIT_W-1:0] element;
        logic             element_valid;
        logic             more;
        logic             error;
    } result_t;

    typedef struct packed {
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
        logic             reverse;
    } scan_req_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [BIT_W-1:0] index;
    } scan_rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

FILE: hdl/bitmap_set_bit_iterator_top.sv
// Top level of the bitmap set-bit iterator: command decode, walk state, bitmap RAM.
// Depends on bsi_pkg, bsi_ram and bsi_scan.
//
// The block holds a bitmap of WORDS words of 32 bits, empty after reset, and walks
// its set bits in either direction. A command transfers at a rising edge with
// start high and busy low; one result follows for every command, shown for one
// cycle with done high, and it cannot be held off. Writing a word, a walk whose
// range is empty, an advance at the bound and an advance with nothing pending
// answer in the cycle after the transfer. A walk start or an advance that has to
// search reads the bitmap one word per cycle from the word where the search
// begins until the first word holding a set bit in range, or the last word of the
// range. Each word is read through the registered read port of the bitmap RAM,
// checked as it comes back, and the result is registered. busy drops in the cycle
// the result is shown, so the next command may transfer at that edge.
// Reset empties the bitmap at once through one valid flag per word; a word never
// written reads as zero.
module bitmap_set_bit_iterator_top
    import bsi_pkg::*;
#(
    parameter int WORDS = DEF_WORDS
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int          AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [31:0] CAP_LAST = 32'(WORDS * WORD_BITS - 1);

    state_t           state_reg, state_next;
    logic [BIT_W-1:0] pidx_reg, pidx_next;
    logic             pv_reg, pv_next;
    logic [BIT_W-1:0] bound_reg, bound_next;
    logic             rev_reg, rev_next;
    logic             done_reg, done_next;
    result_t          res_reg, res_next;
    logic [WORDS-1:0] wvld_reg;
    logic             rvld_reg;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic                 scan_go;
    scan_req_t            scan_req;
    scan_rsp_t            scan_rsp;
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_word;
    logic [AW-1:0]        raddr;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] rd_data;
    logic [BIT_W-1:0]     fwd_bound;
    logic [BIT_W-1:0]     rev_start;
    logic                 widx_ok;

    // clamp to the last bit of the bitmap
    assign fwd_bound = ({20'd0, cmd.end_bit} < CAP_LAST) ? cmd.end_bit
                                                         : CAP_LAST[BIT_W-1:0];
    assign rev_start = ({20'd0, cmd.start_bit} < CAP_LAST) ? cmd.start_bit
                                                           : CAP_LAST[BIT_W-1:0];
    assign widx_ok   = ({25'd0, cmd.word_index} < 32'(WORDS));
    assign waddr     = AW'(cmd.word_index);
    assign raddr     = AW'(rd_word);

    // a word with its flag clear still holds the reset value
    assign rd_data = rvld_reg ? ram_q : '0;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    bsi_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.word_data),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (ram_q)
    );

    bsi_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (scan_go),
        .req     (scan_req),
        .rd_en   (rd_en),
        .rd_word (rd_word),
        .rd_data (rd_data),
        .rsp     (scan_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        pidx_next  = pidx_reg;
        pv_next    = pv_reg;
        bound_next = bound_reg;
        rev_next   = rev_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        scan_go    = 1'b0;
        scan_req   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    case (cmd.op)
                        OP_WRITE:
                        begin
                            // out-of-range word: drop the write, still answer
                            we            = widx_ok;
                            res_next.more = pv_reg;
                            done_next     = 1'b1;
                        end
                        OP_FWD:
                        begin
                            rev_next   = 1'b0;
                            bound_next = fwd_bound;
                            pv_next    = 1'b0;
                            pidx_next  = '0;
                            if (cmd.start_bit > fwd_bound)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                scan_go          = 1'b1;
                                scan_req.lo      = cmd.start_bit;
                                scan_req.hi      = fwd_bound;
                                scan_req.reverse = 1'b0;
                                state_next       = ST_SCAN;
                            end
                        end
                        OP_REV:
                        begin
                            rev_next   = 1'b1;
                            bound_next = cmd.end_bit;
                            pv_next    = 1'b0;
                            pidx_next  = '0;
                            if (cmd.end_bit > rev_start)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                scan_go          = 1'b1;
                                scan_req.lo      = cmd.end_bit;
                                scan_req.hi      = rev_start;
                                scan_req.reverse = 1'b1;
                                state_next       = ST_SCAN;
                            end
                        end
                        OP_ADV:
                        begin
                            if (!pv_reg)
                            begin
                                // nothing pending: flag it, hold all state
                                res_next.error = 1'b1;
                                done_next      = 1'b1;
                            end
                            else
                            begin
                                res_next.element       = pidx_reg;
                                res_next.element_valid = 1'b1;
                                if (rev_reg ? (pidx_reg <= bound_reg)
                                            : (pidx_reg >= bound_reg))
                                begin
                                    // at the bound: the walk ends here
                                    pv_next   = 1'b0;
                                    pidx_next = '0;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    scan_go          = 1'b1;
                                    scan_req.reverse = rev_reg;
                                    scan_req.lo      = rev_reg ? bound_reg : pidx_reg + 1'b1;
                                    scan_req.hi      = rev_reg ? pidx_reg - 1'b1 : bound_reg;
                                    state_next       = ST_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    pv_next       = scan_rsp.hit;
                    pidx_next     = scan_rsp.hit ? scan_rsp.index : '0;
                    res_next.more = scan_rsp.hit;
                    done_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pidx_reg  <= '0;
            pv_reg    <= 1'b0;
            bound_reg <= '0;
            rev_reg   <= 1'b0;
            done_reg  <= 1'b0;
            wvld_reg  <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pidx_reg  <= pidx_next;
            pv_reg    <= pv_next;
            bound_reg <= bound_next;
            rev_reg   <= rev_next;
            done_reg  <= done_next;
            if (we)
            begin
                wvld_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= wvld_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a search is still running");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error) |-> (!result.element_valid && !result.more))
        else $error("error result carries an element or a pending one");

    a_scan_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        scan_rsp.done |-> (state_reg == ST_SCAN))
        else $error("search answer arrived outside a search");

endmodule

FILE: hdl/bsi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/bsi_scan.sv
// Word-serial set-bit search over an inclusive bit range, either direction.
// Streams one word read per cycle into the bitmap RAM; depends on bsi_pkg.
module bsi_scan
    import bsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  scan_req_t            req,
    output logic                 rd_en,
    output logic [WIDX_W-1:0]    rd_word,
    input  logic [WORD_BITS-1:0] rd_data,
    output scan_rsp_t            rsp
);

    localparam logic [WORD_LOG-1:0] POS_MAX = WORD_LOG'(WORD_BITS - 1);

    logic [BIT_W-1:0]  lo_reg, lo_next;
    logic [BIT_W-1:0]  hi_reg, hi_next;
    logic              rev_reg, rev_next;
    logic              active_reg, active_next;
    logic              iss_more_reg, iss_more_next;
    logic [WIDX_W-1:0] iss_word_reg, iss_word_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [WIDX_W-1:0] chk_word_reg, chk_word_next;

    logic [WIDX_W-1:0]    lo_w, hi_w, last_w;
    logic [WORD_BITS-1:0] mask, hits;
    logic [WORD_LOG-1:0]  pos_low, pos_high, pos_sel;
    logic                 hit_any;

    assign lo_w   = lo_reg[BIT_W-1:WORD_LOG];
    assign hi_w   = hi_reg[BIT_W-1:WORD_LOG];
    assign last_w = rev_reg ? lo_w : hi_w;

    // trim the word under check to the part that lies inside the range
    always_comb
    begin
        mask = '1;
        if (chk_word_reg == lo_w)
        begin
            mask = mask & ({WORD_BITS{1'b1}} << lo_reg[WORD_LOG-1:0]);
        end
        if (chk_word_reg == hi_w)
        begin
            mask = mask & ({WORD_BITS{1'b1}} >> (POS_MAX - hi_reg[WORD_LOG-1:0]));
        end
        hits    = rd_data & mask;
        hit_any = |hits;
    end

    always_comb
    begin
        pos_low  = '0;
        pos_high = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                pos_low = WORD_LOG'(i);
            end
        end
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (hits[i])
            begin
                pos_high = WORD_LOG'(i);
            end
        end
        pos_sel = rev_reg ? pos_high : pos_low;
    end

    always_comb
    begin
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        rev_next      = rev_reg;
        active_next   = active_reg;
        iss_more_next = iss_more_reg;
        iss_word_next = iss_word_reg;
        chk_vld_next  = 1'b0;
        chk_word_next = chk_word_reg;
        rd_en         = 1'b0;
        rd_word       = iss_word_reg;
        rsp           = '0;

        if (go)
        begin
            lo_next       = req.lo;
            hi_next       = req.hi;
            rev_next      = req.reverse;
            active_next   = 1'b1;
            iss_more_next = 1'b1;
            iss_word_next = req.reverse ? req.hi[BIT_W-1:WORD_LOG] : req.lo[BIT_W-1:WORD_LOG];
        end
        else if (active_reg)
        begin
            // issue the next word read
            if (iss_more_reg)
            begin
                rd_en         = 1'b1;
                chk_vld_next  = 1'b1;
                chk_word_next = iss_word_reg;
                if (iss_word_reg == last_w)
                begin
                    iss_more_next = 1'b0;
                end
                else if (rev_reg)
                begin
                    iss_word_next = iss_word_reg - 1'b1;
                end
                else
                begin
                    iss_word_next = iss_word_reg + 1'b1;
                end
            end
            // check the word that came back; stop on a hit or at the last word
            if (chk_vld_reg && (hit_any || (chk_word_reg == last_w)))
            begin
                rsp.done      = 1'b1;
                rsp.hit       = hit_any;
                rsp.index     = {chk_word_reg, pos_sel};
                active_next   = 1'b0;
                iss_more_next = 1'b0;
                chk_vld_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            iss_more_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            iss_more_reg <= iss_more_next;
            chk_vld_reg  <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        rev_reg      <= rev_next;
        iss_word_reg <= iss_word_next;
        chk_word_reg <= chk_word_next;
    end

    a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !active_reg)
        else $error("search started while one is running");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> (!active_reg && !chk_vld_reg && !rd_en))
        else $error("search kept running after its answer");

    a_check_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> $past(rd_en))
        else $error("word checked without a read the cycle before");

endmodule
